// ===== rtl/bist_pkg.sv =====
// ----------------------------------------------------------------------------
// bist_pkg: shared types and codes for the bounded integer set table
// Operation and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package bist_pkg;

	localparam int unsigned ValueWidth  = 32;
	localparam int unsigned OpWidth     = 2;
	localparam int unsigned StatusWidth = 3;
	localparam int unsigned CountWidth  = 5;

	localparam logic [OpWidth-1:0] OP_INSERT = 2'd0;
	localparam logic [OpWidth-1:0] OP_REMOVE = 2'd1;
	localparam logic [OpWidth-1:0] OP_QUERY  = 2'd2;

	localparam logic [StatusWidth-1:0] ST_INSERTED = 3'd0;
	localparam logic [StatusWidth-1:0] ST_DUP      = 3'd1;
	localparam logic [StatusWidth-1:0] ST_FULL     = 3'd2;
	localparam logic [StatusWidth-1:0] ST_REMOVED  = 3'd3;
	localparam logic [StatusWidth-1:0] ST_ABSENT   = 3'd4;
	localparam logic [StatusWidth-1:0] ST_FOUND    = 3'd5;

	typedef struct packed {
		logic cmp;    // latch compare result against the broadcast value
		logic shift;  // removal: take the neighbor's entry if at or past the hit
		logic load;   // insert: write the broadcast value into this cell
	} cell_ctrl_t;

endpackage

// ===== rtl/bist_cell.sv =====
// ----------------------------------------------------------------------------
// bist_cell: one slot of the set table
// Holds one entry, compares it with the broadcast value, and passes the
// "hit at or before me" flag toward the tail and its entry toward the head.
// ----------------------------------------------------------------------------
module bist_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bist_pkg::cell_ctrl_t                  ctrl,
	input  logic                                  valid,
	input  logic signed [bist_pkg::ValueWidth-1:0] value,
	input  logic signed [bist_pkg::ValueWidth-1:0] next_entry,
	input  logic                                  hit_in,
	output logic                                  hit_out,
	output logic signed [bist_pkg::ValueWidth-1:0] entry
);

	logic signed [bist_pkg::ValueWidth-1:0] entry_q;
	logic                                   match_q;

	assign entry   = entry_q;
	assign hit_out = hit_in | match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp) begin
			match_q <= valid && (entry_q == value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= value;
		end else if (ctrl.shift && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== rtl/bounded_integer_set_table_core.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_table_core: set of distinct 32-bit values, kept in insertion order
// A row of DEPTH cells holds the elements; remove compacts the row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op and value. Op insert appends
//   a new value unless it is present or the set is full; remove deletes it and
//   closes the gap; query (and the unused code) tests membership.
//   Output channel (out_valid/out_ready) returns one transfer per item:
//   status, present (value held before the operation) and the new count.
//   cfg_we/cfg_wdata write the capacity; it is clamped to DEPTH internally.
// Timing:
//   An item is compared and then updated: in the accept cycle every cell
//   compares its entry with the value; in the update cycle, once the output
//   register is free, the cells shift or load and the result is registered.
//   No new item is taken before that update is done: the cell row limits it.
// Reset clears the count (empty set) and out_valid, and sets capacity
// to 16. While out_ready is low with a result held, the pending item waits
// in its update cycle and no further item is accepted.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [bist_pkg::CountWidth-1:0]        cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [bist_pkg::OpWidth-1:0]           op,
	input  logic signed [bist_pkg::ValueWidth-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bist_pkg::StatusWidth-1:0]       status,
	output logic                                   present,
	output logic [bist_pkg::CountWidth-1:0]        count
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned WW = (CW > bist_pkg::CountWidth) ? CW : bist_pkg::CountWidth;

	logic [bist_pkg::CountWidth-1:0]        capacity_q;
	logic [CW-1:0]                          count_q;
	logic                                   busy_q;
	logic [bist_pkg::OpWidth-1:0]           op_q;
	logic signed [bist_pkg::ValueWidth-1:0] value_q;
	logic                                   out_valid_q;
	logic [bist_pkg::StatusWidth-1:0]       status_q;
	logic                                   present_q;
	logic [bist_pkg::CountWidth-1:0]        count_out_q;

	logic                                   accept;
	logic                                   done;
	logic                                   hit;
	logic                                   room;
	logic                                   do_ins;
	logic                                   do_rem;
	logic [bist_pkg::StatusWidth-1:0]       status_nxt;
	logic [CW-1:0]                          count_nxt;
	logic signed [bist_pkg::ValueWidth-1:0] bcast;

	logic [DEPTH:0]                                 hit_chain;
	logic signed [DEPTH-1:0][bist_pkg::ValueWidth-1:0] entries;
	bist_pkg::cell_ctrl_t [DEPTH-1:0]               ctrl;

	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign done      = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign present   = present_q;
	assign count     = count_out_q;

	// compare against the incoming value, update with the latched one
	assign bcast        = busy_q ? value_q : value;
	assign hit_chain[0] = 1'b0;
	assign hit          = hit_chain[DEPTH];

	assign room = (WW'(count_q) < WW'(capacity_q)) && (WW'(count_q) < WW'(DEPTH));

	always_comb begin
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		count_nxt = count_q;
		priority if (op_q == bist_pkg::OP_INSERT) begin
			if (hit) begin
				status_nxt = bist_pkg::ST_DUP;
			end else if (room) begin
				status_nxt = bist_pkg::ST_INSERTED;
				do_ins     = 1'b1;
				count_nxt  = count_q + CW'(1);
			end else begin
				status_nxt = bist_pkg::ST_FULL;
			end
		end else if (op_q == bist_pkg::OP_REMOVE) begin
			if (hit) begin
				status_nxt = bist_pkg::ST_REMOVED;
				do_rem     = 1'b1;
				count_nxt  = count_q - CW'(1);
			end else begin
				status_nxt = bist_pkg::ST_ABSENT;
			end
		end else begin
			status_nxt = hit ? bist_pkg::ST_FOUND : bist_pkg::ST_ABSENT;
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic signed [bist_pkg::ValueWidth-1:0] nbr;

			if (i == DEPTH - 1) begin : g_tail
				assign nbr = entries[i];
			end else begin : g_mid
				assign nbr = entries[i+1];
			end

			assign ctrl[i].cmp   = accept;
			assign ctrl[i].shift = done && do_rem;
			assign ctrl[i].load  = done && do_ins && (count_q == CW'(i));

			bist_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl[i]),
				.valid      (CW'(i) < count_q),
				.value      (bcast),
				.next_entry (nbr),
				.hit_in     (hit_chain[i]),
				.hit_out    (hit_chain[i+1]),
				.entry      (entries[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= bist_pkg::CountWidth'(16);
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			value_q <= value;
		end
		if (done) begin
			status_q    <= status_nxt;
			present_q   <= hit;
			count_out_q <= bist_pkg::CountWidth'(count_nxt);
		end
	end

endmodule
